// ===== rtl/sobel3_pkg.sv =====
package sobel3_pkg;

  localparam int PIX_W          = 8;
  localparam int GRAD_W         = 11;
  localparam int CFG_WIDTH_W    = 11;
  localparam int CFG_HEIGHT_W   = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int ROW_W          = CFG_HEIGHT_W + 1;
  localparam int S_TDATA_W      = 8;
  localparam int M_TDATA_W      = 24;

  localparam int DEF_MAX_WIDTH     = 1024;
  localparam int DEF_QUEUE_DEPTH   = 4;
  localparam int RESET_IMAGE_WIDTH  = 1024;
  localparam int RESET_IMAGE_HEIGHT = 1024;

  // Beat kind carried on s_tuser
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } sobel3_op_t;

  // Configuration register index
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } sobel3_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  // One 3x3 neighborhood ready for the gradient adders, [row][column]
  typedef struct packed {
    logic [2:0][2:0][PIX_W-1:0] win;
    logic                       last;
  } sobel3_entry_t;

endpackage

// ===== rtl/sobel3_front.sv =====
module sobel3_front #(
  parameter int MAX_WIDTH = sobel3_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [sobel3_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sobel3_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                              s_tuser,
  output logic                              push,
  output sobel3_pkg::sobel3_entry_t         push_data,
  input  logic                              q_full
);
  import sobel3_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WEW = $clog2(MAX_WIDTH + 1);
  localparam int RESET_W_EFF =
    (RESET_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_IMAGE_WIDTH;

  typedef struct packed {
    logic is_last;
    logic col_first;
    logic row_one;
    logic row_below_h;
    logic row_ge2;
    logic row_ge1;
    logic flush;
    pix_t pixel;
  } item_class_t;

  logic [WEW-1:0]          w_eff;
  logic [CFG_HEIGHT_W-1:0] h_eff;
  logic [CW-1:0]           col;
  logic [ROW_W-1:0]        row;

  logic [CFG_WIDTH_W-1:0]  cfg_w_val;
  logic [CFG_HEIGHT_W-1:0] cfg_h_val;

  logic                    s_accept;
  logic                    row_past;
  logic [WEW-1:0]          col_inc;
  logic                    col_wrap;

  logic                    s1_valid;
  item_class_t             s1;
  logic [CW-1:0]           s1_col;
  logic                    s1_has_result;
  logic                    s1_move;

  pix_t                    upper_mem [MAX_WIDTH];
  pix_t                    middle_mem [MAX_WIDTH];
  pix_t                    rd_upper;
  pix_t                    rd_middle;
  logic                    fwd;
  pix_t                    fwd_upper;
  pix_t                    fwd_middle;

  pix_t                    mid_px;
  pix_t                    top_px;
  pix_t                    bot_px;
  logic [2:0][2:0][PIX_W-1:0] win;
  logic [2:0][2:0][PIX_W-1:0] win_next;
  logic [2:0][2:0][PIX_W-1:0] win_edge;

  // Configuration: store the clamped sizes directly
  assign cfg_w_val = cfg_data[CFG_WIDTH_W-1:0];
  assign cfg_h_val = cfg_data[CFG_HEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= WEW'(RESET_W_EFF);
      h_eff <= CFG_HEIGHT_W'(RESET_IMAGE_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH: begin
          if (cfg_w_val == '0) begin
            w_eff <= WEW'(1);
          end else if (32'(cfg_w_val) > 32'(MAX_WIDTH)) begin
            w_eff <= WEW'(MAX_WIDTH);
          end else begin
            w_eff <= WEW'(cfg_w_val);
          end
        end
        REG_IMAGE_HEIGHT: begin
          h_eff <= (cfg_h_val == '0) ? CFG_HEIGHT_W'(1) : cfg_h_val;
        end
        default: begin
          w_eff <= w_eff;
        end
      endcase
    end
  end

  // Accept stage: classify the beat and advance the raster position
  assign s1_has_result = s1.is_last || (s1.col_first ? s1.row_ge2 : s1.row_ge1);
  assign s1_move       = s1_valid && (!s1_has_result || !q_full);
  assign s_tready      = !s1_valid || s1_move;
  assign s_accept      = s_tvalid && s_tready;

  assign row_past = row > {1'b0, h_eff};
  assign col_inc  = WEW'(col) + WEW'(1);
  assign col_wrap = col_inc >= w_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (s_accept) begin
      if (row_past) begin
        col <= '0;
        row <= '0;
      end else if (col_wrap) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1.is_last     <= row_past;
      s1.col_first   <= (col == '0);
      s1.row_one     <= (row == ROW_W'(1));
      s1.row_below_h <= (row < {1'b0, h_eff});
      s1.row_ge2     <= (row >= ROW_W'(2));
      s1.row_ge1     <= (row != '0);
      s1.flush       <= (s_tuser == OP_FLUSH);
      s1.pixel       <= s_tdata[PIX_W-1:0];
      s1_col         <= col;
      // The item ahead writes this column in the same cycle: bypass it
      fwd            <= s1_valid && !s1.is_last && (s1_col == col);
      fwd_upper      <= mid_px;
      fwd_middle     <= bot_px;
    end
  end

  // Line stores: read on accept, written as the item leaves s1
  always_ff @(posedge clk) begin
    if (s_accept) begin
      rd_upper  <= upper_mem[col];
      rd_middle <= middle_mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && !s1.is_last) begin
      upper_mem[s1_col]  <= mid_px;
      middle_mem[s1_col] <= bot_px;
    end
  end

  // Window stage
  always_comb begin
    mid_px = fwd ? fwd_middle : rd_middle;
    top_px = s1.row_one ? mid_px : (fwd ? fwd_upper : rd_upper);
    if (s1.row_below_h) begin
      bot_px = s1.flush ? '0 : s1.pixel;
    end else begin
      bot_px = mid_px;
    end

    for (int i = 0; i < 3; i++) begin
      win_edge[i][0] = win[i][1];
      win_edge[i][1] = win[i][2];
      win_edge[i][2] = win[i][2];
    end

    win_next = win;
    if (s1.col_first) begin
      for (int j = 0; j < 3; j++) begin
        win_next[0][j] = top_px;
        win_next[1][j] = mid_px;
        win_next[2][j] = bot_px;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        win_next[i][0] = win[i][1];
        win_next[i][1] = win[i][2];
      end
      win_next[0][2] = top_px;
      win_next[1][2] = mid_px;
      win_next[2][2] = bot_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_move && !s1.is_last) begin
      win <= win_next;
    end
  end

  assign push           = s1_valid && s1_has_result && !q_full;
  assign push_data.win  = (s1.is_last || s1.col_first) ? win_edge : win_next;
  assign push_data.last = s1.is_last;

  a_restart_after_last : assert property (@(posedge clk) disable iff (rst)
    s_accept && row_past |=> (col == '0) && (row == '0))
    else $error("raster position not cleared after the closing beat");

  a_stall_holds_item : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_col))
    else $error("window stage dropped a stalled item");

endmodule

// ===== rtl/sobel3_queue.sv =====
module sobel3_queue #(
  parameter int DEPTH = sobel3_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  sobel3_pkg::sobel3_entry_t push_data,
  output logic                      full,
  input  logic                      pop,
  output logic                      head_valid,
  output sobel3_pkg::sobel3_entry_t head_data
);
  import sobel3_pkg::*;

  localparam int PW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sobel3_entry_t   slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_push_counts : assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == CNT_W'($past(count) + CNT_W'(1)))
    else $error("queue lost a pushed entry");

endmodule

// ===== rtl/sobel3_back.sv =====
module sobel3_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             head_valid,
  input  sobel3_pkg::sobel3_entry_t        head_data,
  output logic                             pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sobel3_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                             m_tlast
);
  import sobel3_pkg::*;

  localparam int SUM_W = PIX_W + 2;

  logic [SUM_W-1:0]  gx_pos;
  logic [SUM_W-1:0]  gx_neg;
  logic [SUM_W-1:0]  gy_pos;
  logic [SUM_W-1:0]  gy_neg;
  logic [GRAD_W-1:0] grad_x;
  logic [GRAD_W-1:0] grad_y;

  always_comb begin
    gx_pos = SUM_W'(head_data.win[0][2]) + {1'b0, head_data.win[1][2], 1'b0}
           + SUM_W'(head_data.win[2][2]);
    gx_neg = SUM_W'(head_data.win[0][0]) + {1'b0, head_data.win[1][0], 1'b0}
           + SUM_W'(head_data.win[2][0]);
    gy_pos = SUM_W'(head_data.win[2][0]) + {1'b0, head_data.win[2][1], 1'b0}
           + SUM_W'(head_data.win[2][2]);
    gy_neg = SUM_W'(head_data.win[0][0]) + {1'b0, head_data.win[0][1], 1'b0}
           + SUM_W'(head_data.win[0][2]);
    grad_x = GRAD_W'(gx_pos) - GRAD_W'(gx_neg);
    grad_y = GRAD_W'(gy_pos) - GRAD_W'(gy_neg);
  end

  assign pop = head_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {(M_TDATA_W - 2 * GRAD_W)'(0), grad_y, grad_x};
      m_tlast <= head_data.last;
    end
  end

  a_pop_shows : assert property (@(posedge clk) disable iff (rst)
    pop |=> m_tvalid)
    else $error("popped result not presented");

endmodule

// ===== rtl/sobel_gradient_3x3_core.sv =====
// 3x3 Sobel gradient core. Pixels stream in raster order, one beat per clock
// (s_tdata = pixel_value, s_tuser = opcode: pixel or flush), and each pixel
// gives one beat with its raw horizontal and vertical gradient in two's
// complement, borders replicating the nearest edge pixel. The core sustains
// one input beat per clock while the queue has room; the rate is set by the
// window stage, which reads one column of each of the two line stores as a
// beat is taken and writes it back as the beat leaves, so each store needs
// one read and one write port. A result appears image_width+1 input beats
// after its pixel, so after the image_width*image_height pixels of a frame
// send image_width+1 flush beats to drain the frame; the final result
// carries m_tlast and the core then starts the next frame. Results pass the s1
// register, the queue and the m_tdata output register. Sizes are written through
// cfg_we/cfg_addr/cfg_data (0 = image_width, 1 = image_height) between beats;
// a zero size acts as 1 and a width above MAX_WIDTH acts as MAX_WIDTH. Line
// stores need no clearing after reset.
module sobel_gradient_3x3_core #(
  parameter int MAX_WIDTH   = sobel3_pkg::DEF_MAX_WIDTH,
  parameter int QUEUE_DEPTH = sobel3_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [sobel3_pkg::CFG_DATA_W-1:0] cfg_data,
  // Pixel stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sobel3_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] pixel_value
  input  logic                              s_tuser,   // [0] opcode
  // Gradient stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sobel3_pkg::M_TDATA_W-1:0]  m_tdata,   // [10:0] grad_x, [21:11] grad_y
  output logic                              m_tlast    // frame_last
);
  import sobel3_pkg::*;

  // Front to queue
  logic          push;
  sobel3_entry_t push_data;
  logic          q_full;
  // Queue to back
  logic          pop;
  logic          head_valid;
  sobel3_entry_t head_data;

  // Front: take beats, track the raster position, keep the line stores
  // and the 3x3 window, and hand each complete neighborhood to the queue.
  sobel3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Short queue so a stalled output does not hold the window stage at once.
  sobel3_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // Back: weight the neighborhood and hold the result beat until taken.
  sobel3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
